// File: rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is low.
`define AST_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Same, but also checked during reset.
`define AST_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/core/ihs_pkg.sv
// Shared types and constants for the indexed hash set.
package ihs_pkg;

    localparam int DEF_TABLE_SLOTS = 1024;
    localparam int DEF_KEY_BITS    = 32;

    localparam int KIND_W  = 3;
    localparam int IDX_W   = 10;
    localparam int LIMIT_W = 11;
    localparam int STAT_W  = 3;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd768;
    localparam logic [31:0]        HASH_MULT   = 32'd134217689;

    localparam logic [KIND_W-1:0] KIND_PUT    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_LOOKUP = 3'd1;
    localparam logic [KIND_W-1:0] KIND_ERASE  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_READ   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd4;

    typedef enum logic [2:0] {
        OP_PUT, OP_LOOKUP, OP_ERASE, OP_READ, OP_CLEAR
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_INSERTED = 3'd0,
        ST_PRESENT  = 3'd1,
        ST_FOUND    = 3'd2,
        ST_ABSENT   = 3'd3,
        ST_ERASED   = 3'd4,
        ST_FULL     = 3'd5,
        ST_KEY_READ = 3'd6,
        ST_CLEARED  = 3'd7
    } t_status;

    typedef struct packed {
        logic valid;
        t_op  op;
    } t_q_ctl;

    typedef struct packed {
        logic init_busy;
        logic idle;
    } t_back_stat;

endpackage

// File: rtl/core/ihs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ihs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/ihs_front.sv
// Front end: accepts commands, decodes the kind, hashes the key, queues the word.
module ihs_front #(
    parameter int TABLE_SLOTS = ihs_pkg::DEF_TABLE_SLOTS,
    parameter int KEY_BITS    = ihs_pkg::DEF_KEY_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    output logic                             o_busy,
    input  logic [ihs_pkg::KIND_W-1:0]       i_kind,
    input  logic [KEY_BITS-1:0]              i_key,
    input  logic [ihs_pkg::IDX_W-1:0]        i_index_in,
    input  ihs_pkg::t_back_stat              i_stat,
    input  logic                             i_pop,
    output ihs_pkg::t_q_ctl                  o_q_ctl,
    output logic [KEY_BITS-1:0]              o_q_key,
    output logic [ihs_pkg::IDX_W-1:0]        o_q_index,
    output logic [$clog2(TABLE_SLOTS)-1:0]   o_q_home
);

    localparam int SLOT_W = $clog2(TABLE_SLOTS);
    localparam logic [31:0] HM = ihs_pkg::HASH_MULT;
    localparam logic [SLOT_W-1:0] MULT_LO = HM[SLOT_W-1:0];

    ihs_pkg::t_op               r_q_op    [2];
    logic [KEY_BITS-1:0]        r_q_key   [2];
    logic [ihs_pkg::IDX_W-1:0]  r_q_index [2];
    logic [SLOT_W-1:0]          r_q_home  [2];
    logic                       r_wp, r_rp;
    logic [1:0]                 r_cnt;

    ihs_pkg::t_op               dec_op;
    logic                       dec_ok;
    logic                       push;
    logic [KEY_BITS+SLOT_W-1:0] key_sh;
    logic [2*SLOT_W-1:0]        prod;
    logic [SLOT_W-1:0]          home;

    always_comb begin
        dec_ok = 1'b1;
        dec_op = ihs_pkg::OP_PUT;
        unique case (i_kind)
            ihs_pkg::KIND_PUT:    dec_op = ihs_pkg::OP_PUT;
            ihs_pkg::KIND_LOOKUP: dec_op = ihs_pkg::OP_LOOKUP;
            ihs_pkg::KIND_ERASE:  dec_op = ihs_pkg::OP_ERASE;
            ihs_pkg::KIND_READ:   dec_op = ihs_pkg::OP_READ;
            ihs_pkg::KIND_CLEAR:  dec_op = ihs_pkg::OP_CLEAR;
            default:              dec_ok = 1'b0;
        endcase
    end

    // home slot: low bits of (key >> 2) * multiplier
    assign key_sh = {{SLOT_W{1'b0}}, i_key} >> 2;
    assign prod   = key_sh[SLOT_W-1:0] * MULT_LO;
    assign home   = prod[SLOT_W-1:0];

    assign o_busy = (r_cnt == 2'd2) || i_stat.init_busy;
    assign push   = i_start && !o_busy && dec_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_q_op[r_wp]    <= dec_op;
                r_q_key[r_wp]   <= i_key;
                r_q_index[r_wp] <= i_index_in;
                r_q_home[r_wp]  <= home;
                r_wp            <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_pop};
        end
    end

    assign o_q_ctl.valid = (r_cnt != 2'd0);
    assign o_q_ctl.op    = r_q_op[r_rp];
    assign o_q_key       = r_q_key[r_rp];
    assign o_q_index     = r_q_index[r_rp];
    assign o_q_home      = r_q_home[r_rp];

endmodule

// File: rtl/core/ihs_back.sv
// Back end: probe sequencer, table updates, clearing sweep and result register.
module ihs_back #(
    parameter int TABLE_SLOTS = ihs_pkg::DEF_TABLE_SLOTS,
    parameter int KEY_BITS    = ihs_pkg::DEF_KEY_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  ihs_pkg::t_q_ctl                  i_q_ctl,
    input  logic [KEY_BITS-1:0]              i_q_key,
    input  logic [ihs_pkg::IDX_W-1:0]        i_q_index,
    input  logic [$clog2(TABLE_SLOTS)-1:0]   i_q_home,
    output logic                             o_pop,
    input  logic [ihs_pkg::LIMIT_W-1:0]      i_entry_limit,
    output ihs_pkg::t_back_stat              o_stat,
    output logic                             o_result_valid,
    output logic [ihs_pkg::IDX_W-1:0]        o_index_out,
    output logic [ihs_pkg::STAT_W-1:0]       o_status,
    output logic [KEY_BITS-1:0]              o_key_out,
    output logic                             o_key_valid
);

    localparam int SLOT_W = $clog2(TABLE_SLOTS);
    localparam int CNT_W  = SLOT_W + 1;
    localparam int SW_W   = 2 + SLOT_W;
    localparam int KW_W   = KEY_BITS + 1;
    localparam int IDX_W  = ihs_pkg::IDX_W;
    localparam int LIM_W  = (ihs_pkg::LIMIT_W > CNT_W) ? ihs_pkg::LIMIT_W : CNT_W;
    localparam int IXW_W  = IDX_W + SLOT_W;

    localparam logic [1:0] MARK_EMPTY   = 2'd0;
    localparam logic [1:0] MARK_USED    = 2'd1;
    localparam logic [1:0] MARK_DELETED = 2'd2;

    localparam logic [CNT_W-1:0]  SLOTS_C   = CNT_W'(TABLE_SLOTS);
    localparam logic [CNT_W-1:0]  LAST_STEP = CNT_W'(TABLE_SLOTS - 1);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);

    typedef enum logic [2:0] {
        S_INIT, S_IDLE, S_SLOT, S_KEY, S_FIN, S_READ
    } t_state;

    t_state              r_state;
    ihs_pkg::t_op        r_op;
    logic [KEY_BITS-1:0] r_key;
    logic [SLOT_W-1:0]   r_c, r_hole, r_vidx, r_sweep, r_idx;
    logic [CNT_W-1:0]    r_step, r_free_cnt, r_live_cnt;
    logic                r_hole_ok, r_found, r_idx_ok, r_clr;
    logic                r_res_valid, r_key_valid;
    logic [IDX_W-1:0]    r_index_out;
    logic [ihs_pkg::STAT_W-1:0] r_status;
    logic [KEY_BITS-1:0] r_key_out;

    // RAM ports
    logic              slot_we, slot_re;
    logic [SLOT_W-1:0] slot_waddr, slot_raddr;
    logic [SW_W-1:0]   slot_wdata, slot_rdata;
    logic              key_we, key_re;
    logic [SLOT_W-1:0] key_waddr, key_raddr;
    logic [KW_W-1:0]   key_wdata, key_rdata;
    logic              free_we, free_re;
    logic [SLOT_W-1:0] free_waddr, free_raddr;
    logic [SLOT_W-1:0] free_wdata, free_rdata;

    logic [1:0]        slot_mark;
    logic [SLOT_W-1:0] slot_vidx, c_next, new_idx;
    logic              key_hit, last_step, lim_ok, put_ok, put_do;
    logic [LIM_W-1:0]  live_ext, lim_ext;
    logic [IXW_W-1:0]  qidx_ext, v_ext, m_ext, ridx_ext;

    ihs_ram #(.WIDTH(SW_W), .DEPTH(TABLE_SLOTS)) u_slot_ram (
        .i_clk(i_clk), .i_we(slot_we), .i_waddr(slot_waddr), .i_wdata(slot_wdata),
        .i_re(slot_re), .i_raddr(slot_raddr), .o_rdata(slot_rdata)
    );
    ihs_ram #(.WIDTH(KW_W), .DEPTH(TABLE_SLOTS)) u_key_ram (
        .i_clk(i_clk), .i_we(key_we), .i_waddr(key_waddr), .i_wdata(key_wdata),
        .i_re(key_re), .i_raddr(key_raddr), .o_rdata(key_rdata)
    );
    ihs_ram #(.WIDTH(SLOT_W), .DEPTH(TABLE_SLOTS)) u_free_ram (
        .i_clk(i_clk), .i_we(free_we), .i_waddr(free_waddr), .i_wdata(free_wdata),
        .i_re(free_re), .i_raddr(free_raddr), .o_rdata(free_rdata)
    );

    assign slot_mark = slot_rdata[SW_W-1 -: 2];
    assign slot_vidx = slot_rdata[SLOT_W-1:0];
    assign key_hit   = key_rdata[KEY_BITS] && (key_rdata[KEY_BITS-1:0] == r_key);
    assign last_step = (r_step == LAST_STEP);
    assign c_next    = r_c + 1'b1;

    // effective limit is min(entry_limit, TABLE_SLOTS)
    assign live_ext = LIM_W'(r_live_cnt);
    assign lim_ext  = LIM_W'(i_entry_limit);
    assign lim_ok   = (r_live_cnt < SLOTS_C) && (live_ext < lim_ext);
    assign put_ok   = (r_free_cnt != '0) || lim_ok;
    assign new_idx  = (r_free_cnt != '0) ? free_rdata : r_live_cnt[SLOT_W-1:0];
    assign put_do   = !r_found && put_ok && r_hole_ok;

    assign qidx_ext = {{SLOT_W{1'b0}}, i_q_index};
    assign v_ext    = {{IDX_W{1'b0}}, r_vidx};
    assign m_ext    = {{IDX_W{1'b0}}, new_idx};
    assign ridx_ext = {{IDX_W{1'b0}}, r_idx};

    always_comb begin
        slot_we    = 1'b0;
        slot_waddr = r_sweep;
        slot_wdata = {MARK_EMPTY, {SLOT_W{1'b0}}};
        slot_re    = 1'b0;
        slot_raddr = c_next;
        key_we     = 1'b0;
        key_waddr  = r_sweep;
        key_wdata  = '0;
        key_re     = 1'b0;
        key_raddr  = slot_vidx;
        free_we    = 1'b0;
        free_waddr = r_free_cnt[SLOT_W-1:0];
        free_wdata = r_vidx;
        free_re    = 1'b0;
        free_raddr = r_free_cnt[SLOT_W-1:0] - 1'b1;
        o_pop      = 1'b0;
        unique case (r_state)
            S_INIT: begin
                slot_we = 1'b1;
                key_we  = 1'b1;
            end
            S_IDLE: begin
                if (i_q_ctl.valid) begin
                    o_pop = 1'b1;
                    case (i_q_ctl.op)
                        ihs_pkg::OP_READ: begin
                            key_re    = 1'b1;
                            key_raddr = qidx_ext[SLOT_W-1:0];
                        end
                        ihs_pkg::OP_CLEAR: ;
                        default: begin
                            slot_re    = 1'b1;
                            slot_raddr = i_q_home;
                            free_re    = 1'b1;
                        end
                    endcase
                end
            end
            S_SLOT: begin
                case (slot_mark)
                    MARK_EMPTY: ;
                    MARK_DELETED: slot_re = !last_step;
                    default: key_re = 1'b1;
                endcase
            end
            S_KEY: slot_re = !key_hit && !last_step;
            S_FIN: begin
                if (r_op == ihs_pkg::OP_PUT && put_do) begin
                    slot_we    = 1'b1;
                    slot_waddr = r_hole;
                    slot_wdata = {MARK_USED, new_idx};
                    key_we     = 1'b1;
                    key_waddr  = new_idx;
                    key_wdata  = {1'b1, r_key};
                end else if (r_op == ihs_pkg::OP_ERASE && r_found) begin
                    slot_we    = 1'b1;
                    slot_waddr = r_c;
                    slot_wdata = {MARK_DELETED, r_vidx};
                    key_we     = 1'b1;
                    key_waddr  = r_vidx;
                    key_wdata  = '0;
                    free_we    = (r_free_cnt < SLOTS_C);
                end
            end
            S_READ: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_sweep     <= '0;
            r_clr       <= 1'b0;
            r_free_cnt  <= '0;
            r_live_cnt  <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= 1'b0;
            unique case (r_state)
                S_INIT: begin
                    r_sweep <= r_sweep + 1'b1;
                    if (r_sweep == LAST_SLOT) begin
                        r_state    <= S_IDLE;
                        r_free_cnt <= '0;
                        r_live_cnt <= '0;
                        if (r_clr) begin
                            r_clr       <= 1'b0;
                            r_res_valid <= 1'b1;
                            r_index_out <= '0;
                            r_status    <= ihs_pkg::ST_CLEARED;
                            r_key_out   <= '0;
                            r_key_valid <= 1'b0;
                        end
                    end
                end
                S_IDLE: begin
                    if (i_q_ctl.valid) begin
                        r_op      <= i_q_ctl.op;
                        r_key     <= i_q_key;
                        r_c       <= i_q_home;
                        r_step    <= '0;
                        r_hole_ok <= 1'b0;
                        r_found   <= 1'b0;
                        r_idx     <= qidx_ext[SLOT_W-1:0];
                        r_idx_ok  <= (qidx_ext < IXW_W'(TABLE_SLOTS));
                        case (i_q_ctl.op)
                            ihs_pkg::OP_READ:  r_state <= S_READ;
                            ihs_pkg::OP_CLEAR: begin
                                r_clr   <= 1'b1;
                                r_sweep <= '0;
                                r_state <= S_INIT;
                            end
                            default: r_state <= S_SLOT;
                        endcase
                    end
                end
                S_SLOT: begin
                    case (slot_mark)
                        MARK_EMPTY: begin
                            if (!r_hole_ok) begin
                                r_hole    <= r_c;
                                r_hole_ok <= 1'b1;
                            end
                            r_state <= S_FIN;
                        end
                        MARK_DELETED: begin
                            if (!r_hole_ok) begin
                                r_hole    <= r_c;
                                r_hole_ok <= 1'b1;
                            end
                            if (last_step) begin
                                r_state <= S_FIN;
                            end else begin
                                r_c    <= c_next;
                                r_step <= r_step + 1'b1;
                            end
                        end
                        default: begin
                            r_vidx  <= slot_vidx;
                            r_state <= S_KEY;
                        end
                    endcase
                end
                S_KEY: begin
                    if (key_hit) begin
                        r_found <= 1'b1;
                        r_state <= S_FIN;
                    end else if (last_step) begin
                        r_state <= S_FIN;
                    end else begin
                        r_c     <= c_next;
                        r_step  <= r_step + 1'b1;
                        r_state <= S_SLOT;
                    end
                end
                S_FIN: begin
                    r_res_valid <= 1'b1;
                    r_key_out   <= '0;
                    r_key_valid <= 1'b0;
                    r_index_out <= '0;
                    r_state     <= S_IDLE;
                    case (r_op)
                        ihs_pkg::OP_PUT: begin
                            if (r_found) begin
                                r_index_out <= v_ext[IDX_W-1:0];
                                r_status    <= ihs_pkg::ST_PRESENT;
                            end else if (put_do) begin
                                r_index_out <= m_ext[IDX_W-1:0];
                                r_status    <= ihs_pkg::ST_INSERTED;
                                r_live_cnt  <= r_live_cnt + 1'b1;
                                if (r_free_cnt != '0) begin
                                    r_free_cnt <= r_free_cnt - 1'b1;
                                end
                            end else begin
                                r_status <= ihs_pkg::ST_FULL;
                            end
                        end
                        ihs_pkg::OP_LOOKUP: begin
                            if (r_found) begin
                                r_index_out <= v_ext[IDX_W-1:0];
                                r_status    <= ihs_pkg::ST_FOUND;
                            end else begin
                                r_status <= ihs_pkg::ST_ABSENT;
                            end
                        end
                        default: begin
                            if (r_found) begin
                                r_index_out <= v_ext[IDX_W-1:0];
                                r_status    <= ihs_pkg::ST_ERASED;
                                if (r_free_cnt < SLOTS_C) begin
                                    r_free_cnt <= r_free_cnt + 1'b1;
                                end
                                if (r_live_cnt != '0) begin
                                    r_live_cnt <= r_live_cnt - 1'b1;
                                end
                            end else begin
                                r_status <= ihs_pkg::ST_ABSENT;
                            end
                        end
                    endcase
                end
                S_READ: begin
                    r_res_valid <= 1'b1;
                    r_index_out <= ridx_ext[IDX_W-1:0];
                    r_status    <= ihs_pkg::ST_KEY_READ;
                    r_key_valid <= r_idx_ok && key_rdata[KEY_BITS];
                    r_key_out   <= (r_idx_ok && key_rdata[KEY_BITS]) ?
                                   key_rdata[KEY_BITS-1:0] : '0;
                    r_state     <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stat.init_busy = (r_state == S_INIT) && !r_clr;
    assign o_stat.idle      = (r_state == S_IDLE);

    assign o_result_valid = r_res_valid;
    assign o_index_out    = r_index_out;
    assign o_status       = r_status;
    assign o_key_out      = r_key_out;
    assign o_key_valid    = r_key_valid;

endmodule

// File: rtl/core/indexed_hash_set.sv
// Top level of the indexed hash set: front end, command queue, back end, limit register.
//
//  channel   | signals                                  | handshake
//  ----------+------------------------------------------+---------------------------
//  command   | i_kind, i_key, i_index_in                | start high, busy low
//  result    | o_index_out, o_status, o_key_out,        | o_result_valid, one cycle,
//            | o_key_valid                              | no back-pressure
//  config    | i_cfg_data (entry_limit)                 | i_cfg_valid && o_cfg_ready
//
// Sequence: from the pop, read key goes through S_READ; put, look up and erase take
//   S_SLOT per empty/tombstone slot and S_SLOT then S_KEY per used slot, over at most
//   TABLE_SLOTS slots, then S_FIN. Clear sweeps one slot per cycle. Commands are queued first.
// Reset: synchronous active-low, then a clearing pass over every slot with busy high.
// Stalls: a two-word queue decouples intake from the probe engine; busy rises when
//   it is full. Results cannot be stalled.
module indexed_hash_set #(
    parameter int TABLE_SLOTS = ihs_pkg::DEF_TABLE_SLOTS,  // power of two
    parameter int KEY_BITS    = ihs_pkg::DEF_KEY_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // command
    input  logic                          start,
    output logic                          busy,
    input  logic [ihs_pkg::KIND_W-1:0]    i_kind,
    input  logic [KEY_BITS-1:0]           i_key,
    input  logic [ihs_pkg::IDX_W-1:0]     i_index_in,
    // result
    output logic                          o_result_valid,
    output logic [ihs_pkg::IDX_W-1:0]     o_index_out,
    output logic [ihs_pkg::STAT_W-1:0]    o_status,
    output logic [KEY_BITS-1:0]           o_key_out,
    output logic                          o_key_valid,
    // config
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ihs_pkg::LIMIT_W-1:0]   i_cfg_data
);

    localparam int SLOT_W = $clog2(TABLE_SLOTS);

    logic [ihs_pkg::LIMIT_W-1:0] r_entry_limit;

    ihs_pkg::t_q_ctl            q_ctl;
    ihs_pkg::t_back_stat        back_stat;
    logic [KEY_BITS-1:0]        q_key;
    logic [ihs_pkg::IDX_W-1:0]  q_index;
    logic [SLOT_W-1:0]          q_home;
    logic                       pop;

    // limit register; always writable; software must write it only while idle (the block does not enforce it)
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_limit <= ihs_pkg::LIMIT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_entry_limit <= i_cfg_data;
        end
    end

    // intake, decode, hash and queue
    ihs_front #(.TABLE_SLOTS(TABLE_SLOTS), .KEY_BITS(KEY_BITS)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .o_busy     (busy),
        .i_kind     (i_kind),
        .i_key      (i_key),
        .i_index_in (i_index_in),
        .i_stat     (back_stat),
        .i_pop      (pop),
        .o_q_ctl    (q_ctl),
        .o_q_key    (q_key),
        .o_q_index  (q_index),
        .o_q_home   (q_home)
    );

    // probe engine, table writes and result register
    ihs_back #(.TABLE_SLOTS(TABLE_SLOTS), .KEY_BITS(KEY_BITS)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_ctl        (q_ctl),
        .i_q_key        (q_key),
        .i_q_index      (q_index),
        .i_q_home       (q_home),
        .o_pop          (pop),
        .i_entry_limit  (r_entry_limit),
        .o_stat         (back_stat),
        .o_result_valid (o_result_valid),
        .o_index_out    (o_index_out),
        .o_status       (o_status),
        .o_key_out      (o_key_out),
        .o_key_valid    (o_key_valid)
    );

endmodule

// File: rtl/core/ihs_checker.sv
// Port-level checks for the indexed hash set, bound to the top level.
`include "assert_macros.svh"

module ihs_checker #(
    parameter int KEY_BITS = ihs_pkg::DEF_KEY_BITS
) (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_result_valid,
    input logic [ihs_pkg::IDX_W-1:0]  o_index_out,
    input logic [ihs_pkg::STAT_W-1:0] o_status,
    input logic [KEY_BITS-1:0]        o_key_out,
    input logic                       o_key_valid
);

    logic st_read;
    logic st_no_idx;
    logic kv_res;
    logic key_res;

    assign st_read   = (o_status == ihs_pkg::ST_KEY_READ);
    assign st_no_idx = (o_status == ihs_pkg::ST_ABSENT) || (o_status == ihs_pkg::ST_FULL)
                       || (o_status == ihs_pkg::ST_CLEARED);
    assign kv_res    = o_result_valid && o_key_valid;
    assign key_res   = o_result_valid && (o_key_out != '0);

    // a result strobe is never followed directly by another
    `AST_CLK(a_strobe_gap, i_clk, i_rst_n, o_result_valid |=> !o_result_valid, "adjacent results")

    // key_valid only on a key read
    `AST_CLK(a_kv_read, i_clk, i_rst_n, kv_res |-> st_read, "key_valid outside key read")

    // a nonzero key comes only with key_valid
    `AST_CLK(a_key_zero, i_clk, i_rst_n, key_res |-> o_key_valid, "key without key_valid")

    // absent, full and cleared carry index zero
    `AST_CLK(a_idx_zero, i_clk, i_rst_n, (o_result_valid && st_no_idx) |-> (o_index_out == '0), "nonzero index")

endmodule

bind indexed_hash_set ihs_checker #(.KEY_BITS(KEY_BITS)) u_ihs_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_result_valid (o_result_valid),
    .o_index_out    (o_index_out),
    .o_status       (o_status),
    .o_key_out      (o_key_out),
    .o_key_valid    (o_key_valid)
);
